>>> sv/sdr_pkg.sv
package sdr_pkg;

    // Operand width and division slicing
    localparam int DATA_WIDTH     = 32;
    localparam int BITS_PER_STAGE = 4;
    localparam int NUM_STAGES     = (DATA_WIDTH + BITS_PER_STAGE - 1) / BITS_PER_STAGE;

    typedef logic        [DATA_WIDTH-1:0] t_word;
    typedef logic signed [DATA_WIDTH-1:0] t_sword;

    localparam t_word MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam t_word ALL_ONES = {DATA_WIDTH{1'b1}};

    typedef enum logic {
        OP_QUOTIENT  = 1'b0,
        OP_REMAINDER = 1'b1
    } t_opcode;

    // Payload carried down the divide pipeline
    typedef struct packed {
        logic  is_rem;
        logic  neg_q;
        logic  neg_r;
        logic  zero_b;
        logic  zdiv;
        logic  ovf;
        t_word dividend;
        t_word quo;
        t_word rem;
        t_word dvs;
    } t_div_stage;

endpackage

>>> sv/sdr_if.sv
interface sdr_in_if;
    import sdr_pkg::*;
    logic    valid;
    logic    ready;
    logic    opcode;
    t_sword  dividend;
    t_sword  divisor;
    modport source (output valid, opcode, dividend, divisor, input ready);
    modport sink   (input valid, opcode, dividend, divisor, output ready);
endinterface

interface sdr_out_if;
    import sdr_pkg::*;
    logic    valid;
    logic    ready;
    t_sword  result;
    logic    zero_divide;
    logic    overflow;
    modport source (output valid, result, zero_divide, overflow, input ready);
    modport sink   (input valid, result, zero_divide, overflow, output ready);
endinterface

interface sdr_cfg_if;
    logic valid;
    logic ready;
    logic zero_trap_enable;
    modport source (output valid, zero_trap_enable, input ready);
    modport sink   (input valid, zero_trap_enable, output ready);
endinterface

>>> sv/signed_int_divide_remainder_top.sv
// Signed 32-bit truncating divide / remainder, C semantics. Each transfer on
// i_in carries an opcode (quotient or remainder), a dividend and a divisor;
// each produces exactly one transfer on o_out, in order. The quotient rounds
// toward zero and the remainder takes the sign of the dividend. A zero divisor
// returns the dividend unchanged and flags zero_divide when zero_trap_enable
// (reset 1, written over i_cfg) is set. Most-negative / -1 wraps to the most
// negative value (remainder 0) and flags overflow. Throughput is one transfer
// per cycle while o_out is not stalled; the pipeline holds one operand
// register, NUM_STAGES restoring-divide stages of BITS_PER_STAGE steps each,
// and the result register. The pipeline moves as a whole whenever the result
// register is empty or being taken, so backpressure on o_out holds every
// stage in place.
module signed_int_divide_remainder_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sdr_in_if.sink          i_in,
    sdr_out_if.source       o_out,
    sdr_cfg_if.sink         i_cfg
);
    import sdr_pkg::*;

    // Trap enable register
    logic r_trap;

    // Pipeline valids: [0] operand stage, [1..NUM_STAGES] divide stages
    logic [NUM_STAGES:0] r_vld;
    t_div_stage          r_st [NUM_STAGES+1];

    // Result register
    logic   r_out_valid;
    t_word  r_result;
    logic   r_zdiv;
    logic   r_ovf;

    logic       w_adv;
    t_div_stage n_st0;
    t_word      n_result;

    // Whole pipeline advances unless the result register is held
    assign w_adv       = !r_out_valid || o_out.ready;
    assign i_in.ready  = w_adv;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trap      <= 1'b1;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_trap <= i_cfg.zero_trap_enable;
            end
            if (w_adv) begin
                r_vld       <= {r_vld[NUM_STAGES-1:0], i_in.valid};
                r_out_valid <= r_vld[NUM_STAGES];
            end
        end
    end

    // Operand stage: signs, special cases, magnitudes
    always_comb begin
        logic  na;
        logic  nb;
        t_word a;
        t_word b;
        a  = t_word'(i_in.dividend);
        b  = t_word'(i_in.divisor);
        na = a[DATA_WIDTH-1];
        nb = b[DATA_WIDTH-1];
        n_st0.is_rem   = (i_in.opcode == OP_REMAINDER);
        n_st0.neg_q    = na ^ nb;
        n_st0.neg_r    = na;
        n_st0.zero_b   = (b == '0);
        n_st0.zdiv     = (b == '0) && r_trap;
        n_st0.ovf      = (a == MOST_NEG) && (b == ALL_ONES);
        n_st0.dividend = a;
        // Most negative value negates to itself, i.e. its unsigned magnitude
        n_st0.quo      = na ? (t_word'(0) - a) : a;
        n_st0.rem      = '0;
        n_st0.dvs      = nb ? (t_word'(0) - b) : b;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_st[0] <= n_st0;
        end
    end

    // Restoring divide: BITS_PER_STAGE quotient bits per stage
    for (genvar k = 1; k <= NUM_STAGES; k++) begin : g_div
        t_div_stage n_stg;

        always_comb begin
            t_word                v_quo;
            t_word                v_rem;
            logic [DATA_WIDTH:0]  v_ext;
            n_stg = r_st[k-1];
            v_quo = r_st[k-1].quo;
            v_rem = r_st[k-1].rem;
            v_ext = '0;
            for (int j = 0; j < BITS_PER_STAGE; j++) begin
                if ((k - 1) * BITS_PER_STAGE + j < DATA_WIDTH) begin
                    v_ext = {v_rem, v_quo[DATA_WIDTH-1]};
                    v_quo = {v_quo[DATA_WIDTH-2:0], 1'b0};
                    if (v_ext >= {1'b0, r_st[k-1].dvs}) begin
                        v_ext    = v_ext - {1'b0, r_st[k-1].dvs};
                        v_quo[0] = 1'b1;
                    end
                    v_rem = v_ext[DATA_WIDTH-1:0];
                end
            end
            n_stg.quo = v_quo;
            n_stg.rem = v_rem;
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_st[k] <= n_stg;
            end
        end
    end

    // Sign fix-up and result select
    always_comb begin
        t_word q;
        t_word r;
        q = r_st[NUM_STAGES].quo;
        r = r_st[NUM_STAGES].rem;
        if (r_st[NUM_STAGES].zero_b) begin
            n_result = r_st[NUM_STAGES].dividend;
        end else if (r_st[NUM_STAGES].is_rem) begin
            n_result = r_st[NUM_STAGES].neg_r ? (t_word'(0) - r) : r;
        end else begin
            // overflow case: magnitude equals MOST_NEG, same sign, wraps naturally
            n_result = r_st[NUM_STAGES].neg_q ? (t_word'(0) - q) : q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_result <= n_result;
            r_zdiv   <= r_st[NUM_STAGES].zdiv;
            r_ovf    <= r_st[NUM_STAGES].ovf;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.result      = t_sword'(r_result);
    assign o_out.zero_divide = r_zdiv;
    assign o_out.overflow    = r_ovf;

endmodule

>>> sv/sdr_checker.sv
module sdr_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input sdr_pkg::t_word        i_out_result,
    input logic                  i_out_zero_divide,
    input logic                  i_out_overflow
);
    import sdr_pkg::*;

    // Output is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // Input is never blocked while the result slot is free
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result slot");

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_result))
        else $error("stalled result changed");

    // Zero divisor and overflow are exclusive
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_zero_divide && i_out_overflow))
        else $error("both flags set");

    // Overflow gives wrapped quotient or zero remainder
    a_ovf_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_overflow |-> i_out_result == MOST_NEG || i_out_result == '0)
        else $error("bad overflow result");

endmodule

bind signed_int_divide_remainder_top sdr_checker u_sdr_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_result      (o_out.result),
    .i_out_zero_divide (o_out.zero_divide),
    .i_out_overflow    (o_out.overflow)
);
